// File: sv/adev_pkg.sv
// Shared types and constants for the Allan deviation accumulator.
`default_nettype none
package adev_pkg;
    localparam int SAMPLE_BITS_DEF       = 16;
    localparam int CLUSTER_SIZE_BITS_DEF = 12;
    localparam int SQ_BITS               = 64;
    localparam int RES_BITS              = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_sample;   // accumulate the accepted sample
        logic div_start;     // load the per-cluster divider
        logic div_step;      // advance one divider bit
        logic sq_lo;         // multiply quotient by its low half
        logic div_done;      // finish the square and add
        logic fin_start;     // load the final divide (sum / D)
        logic fin_step;      // advance one final-divide bit
        logic m1_start;      // load divide of Q by M+1
        logic m1_step;
        logic rt_start;      // load square root of Q
        logic rt_sel_q2;     // root source: 0 = Q, 1 = Q/(M+1)
        logic rt_step;
        logic rt_store_dev;  // store root as deviation
        logic rt_store_err;  // store root as error bound
        logic clear;         // clear record state
        logic load_out;      // load result register
    } adev_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cluster_done;  // sample completes a cluster with a previous one
        logic few_clusters;  // fewer than two full clusters
    } adev_sts_t;
endpackage
`default_nettype wire

// File: sv/allan_deviation_accumulator.sv
// Top level of the non-overlapping Allan deviation accumulator.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | in        | in_valid/in_stall  | sample, last_sample
//  out     | out       | out_valid/out_stall| deviation, error_bound, status
//  cfg     | in        | cfg_valid/cfg_ready| cfg_data (cluster_size)
//
// A sample leaves the input free unless it is the last or closes a cluster
// after a previous one; such a one stalls the input while the divider produces
// SAMPLE_BITS+CLUSTER_SIZE_BITS+10 (38) quotient bits and the quotient is
// squared and added. After the last sample the input stalls while the sum is
// divided by D and Q by M+1 and each quotient is rooted; out_valid then rises
// once any earlier result has gone; under two clusters all four are skipped.
// Reset clears all record state and sets size 1. A result holds in the output
// register while out_stall is high; samples are still taken meanwhile.
`default_nettype none
module allan_deviation_accumulator #(
    parameter int SAMPLE_BITS       = adev_pkg::SAMPLE_BITS_DEF,
    parameter int CLUSTER_SIZE_BITS = adev_pkg::CLUSTER_SIZE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CLUSTER_SIZE_BITS:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                          last_sample,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [adev_pkg::RES_BITS-1:0]      deviation,
    output logic [adev_pkg::RES_BITS-1:0]      error_bound,
    output logic                               status
);
    import adev_pkg::*;

    adev_cmd_t cmd;
    adev_sts_t sts;
    logic [CLUSTER_SIZE_BITS:0] size_reg, size_next;

    // Clamp writes above 2^CLUSTER_SIZE_BITS at write time.
    always_comb
    begin
        if (cfg_data > (CLUSTER_SIZE_BITS+1)'(1) << CLUSTER_SIZE_BITS)
            size_next = (CLUSTER_SIZE_BITS+1)'(1) << CLUSTER_SIZE_BITS;
        else
            size_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= (CLUSTER_SIZE_BITS+1)'(1);
        else if (cfg_valid && cfg_ready)
            size_reg <= size_next;
    end

    adev_ctrl #(.SAMPLE_BITS(SAMPLE_BITS), .CLUSTER_SIZE_BITS(CLUSTER_SIZE_BITS)) u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .last_sample,
        .out_valid, .out_stall, .cfg_ready, .sts, .cmd
    );

    adev_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .CLUSTER_SIZE_BITS(CLUSTER_SIZE_BITS)) u_dp (
        .clk, .rst_n, .size_cfg(size_reg), .sample, .cmd, .sts,
        .deviation, .error_bound, .status
    );

    // Hold the result while stalled.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(deviation))
        else $error("result changed under stall");
    // Take a register write only with the block idle and no result waiting.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !in_stall && !out_valid)
        else $error("register write offered while busy");
    // Status set implies zero fields.
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> deviation == '0 && error_bound == '0)
        else $error("flagged result not zero");
endmodule
`default_nettype wire

// File: sv/adev_datapath.sv
// Datapath: cluster sums, shared bit-serial divider, square root and result register.
`default_nettype none
module adev_datapath #(
    parameter int SAMPLE_BITS       = adev_pkg::SAMPLE_BITS_DEF,
    parameter int CLUSTER_SIZE_BITS = adev_pkg::CLUSTER_SIZE_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [CLUSTER_SIZE_BITS:0]   size_cfg,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire adev_pkg::adev_cmd_t          cmd,
    output adev_pkg::adev_sts_t               sts,
    output logic [adev_pkg::RES_BITS-1:0]     deviation,
    output logic [adev_pkg::RES_BITS-1:0]     error_bound,
    output logic                              status
);
    import adev_pkg::*;

    localparam int CSB   = CLUSTER_SIZE_BITS;
    localparam int SUM_W = SAMPLE_BITS + CSB + 1;
    localparam int MAG_W = SUM_W + 1;
    localparam int NUM_W = MAG_W + 8;
    localparam int LO_W  = (NUM_W + 1) / 2;  // low half of the quotient
    localparam int PP_W  = NUM_W + LO_W;
    localparam int DV_W  = 80;  // dividend width for the final divide
    localparam int DS_W  = 34;  // divisor width (D below 2^33)
    localparam int RM_W  = DS_W + 1;

    logic [CSB:0]               size_eff;
    logic signed [SUM_W-1:0]    csum_reg, csum_next, psum_reg;
    logic                       have_prev_reg;
    logic [CSB-1:0]             cnt_reg;
    logic [31:0]                m_reg;
    logic [SQ_BITS-1:0]         sq_reg;
    logic                       cdone;

    // Map a configured size of 0 to 1; the top level clamps sizes above 2^CSB.
    always_comb
    begin
        if (size_cfg == '0)
            size_eff = {{CSB{1'b0}}, 1'b1};
        else
            size_eff = size_cfg;
    end

    assign csum_next = csum_reg + SUM_W'(sample);
    assign cdone     = ({1'b0, cnt_reg} + 1'b1) >= size_eff;
    assign sts.cluster_done = cmd.take_sample & cdone & have_prev_reg;
    assign sts.few_clusters = (m_reg < 32'd2);

    // Shared restoring divider: quotient/dividend shift register + remainder.
    logic [DV_W-1:0] dq_reg;
    logic [RM_W-1:0] rm_reg;
    logic [DS_W-1:0] ds_reg;
    logic [RM_W-1:0] trial;
    logic            fits;

    assign trial = {rm_reg[RM_W-2:0], dq_reg[DV_W-1]};
    assign fits  = trial >= {1'b0, ds_reg};

    // Per-cluster dividend: |diff|*256 + size/2, left-aligned in dq.
    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]        mag;
    logic [NUM_W-1:0]        num;
    assign diff = MAG_W'(csum_next) - MAG_W'(psum_reg);
    assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    assign num  = {mag, 8'd0} + NUM_W'(size_eff >> 1);

    logic [33:0] d_val;
    assign d_val = {1'b0, m_reg - 32'd1, 1'b0};

    // Square root state.
    logic [SQ_BITS-1:0] rv_reg, rr_reg, rb_reg;
    logic [SQ_BITS-1:0] q_reg;
    logic [RES_BITS-1:0] dev_reg, err_reg;
    logic [SQ_BITS-1:0] rsum;
    assign rsum = rr_reg + rb_reg;

    // Square of the quotient modulo 2^64 in two passes over one multiplier:
    // first by the low half, then by the high half shifted into place.
    logic [NUM_W-1:0]   qc;
    logic [LO_W-1:0]    mb;
    logic [PP_W-1:0]    prod;
    logic [PP_W-1:0]    pp_reg;
    logic [SQ_BITS-1:0] sq_wrap;
    logic [SQ_BITS:0]   acc;
    assign qc      = dq_reg[NUM_W-1:0];
    assign mb      = cmd.sq_lo ? qc[LO_W-1:0] : LO_W'(qc[NUM_W-1:LO_W]);
    assign prod    = qc * mb;
    assign sq_wrap = SQ_BITS'(pp_reg) + SQ_BITS'({prod, {LO_W{1'b0}}});
    assign acc     = {1'b0, sq_reg} + {1'b0, sq_wrap};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csum_reg      <= '0;
            psum_reg      <= '0;
            have_prev_reg <= 1'b0;
            cnt_reg       <= '0;
            m_reg         <= '0;
            sq_reg        <= '0;
        end
        else if (cmd.clear)
        begin
            csum_reg      <= '0;
            psum_reg      <= '0;
            have_prev_reg <= 1'b0;
            cnt_reg       <= '0;
            m_reg         <= '0;
            sq_reg        <= '0;
        end
        else
        begin
            if (cmd.take_sample)
            begin
                if (cdone)
                begin
                    psum_reg      <= csum_next;
                    have_prev_reg <= 1'b1;
                    if (m_reg != 32'hFFFF_FFFF)
                        m_reg <= m_reg + 32'd1;
                    csum_reg <= '0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    csum_reg <= csum_next;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
            end
            if (cmd.div_done)
                sq_reg <= acc[SQ_BITS] ? '1 : acc[SQ_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dq_reg <= {num, {(DV_W-NUM_W){1'b0}}};
            rm_reg <= '0;
            ds_reg <= DS_W'(size_eff);
        end
        else if (cmd.fin_start)
        begin
            dq_reg <= {sq_reg, 16'd0};
            rm_reg <= '0;
            ds_reg <= d_val;
        end
        else if (cmd.m1_start)
        begin
            dq_reg <= {q_reg, 16'd0};
            rm_reg <= '0;
            ds_reg <= DS_W'({1'b0, m_reg} + 33'd1);
        end
        else if (cmd.div_step || cmd.fin_step || cmd.m1_step)
        begin
            dq_reg <= {dq_reg[DV_W-2:0], fits};
            rm_reg <= fits ? trial - {1'b0, ds_reg} : trial;
        end
        if (cmd.sq_lo)
            pp_reg <= prod;
        if (cmd.rt_start)
        begin
            // Saturate Q when the quotient exceeds 64 bits.
            if (cmd.rt_sel_q2)
                rv_reg <= dq_reg[SQ_BITS-1+16:16];
            else
            begin
                rv_reg <= (dq_reg[DV_W-1:SQ_BITS] != '0) ? '1 : dq_reg[SQ_BITS-1:0];
                q_reg  <= (dq_reg[DV_W-1:SQ_BITS] != '0) ? '1 : dq_reg[SQ_BITS-1:0];
            end
            rr_reg <= '0;
            rb_reg <= 64'h4000_0000_0000_0000;
        end
        else if (cmd.rt_step)
        begin
            if (rv_reg >= rsum)
            begin
                rv_reg <= rv_reg - rsum;
                rr_reg <= (rr_reg >> 1) + rb_reg;
            end
            else
                rr_reg <= rr_reg >> 1;
            rb_reg <= rb_reg >> 2;
        end
        if (cmd.rt_store_dev)
            dev_reg <= rr_reg[RES_BITS-1:0];
        if (cmd.rt_store_err)
            err_reg <= rr_reg[RES_BITS-1:0];
        if (cmd.load_out)
        begin
            deviation   <= sts.few_clusters ? '0 : dev_reg;
            error_bound <= sts.few_clusters ? '0 : err_reg;
            status      <= sts.few_clusters;
        end
    end
endmodule
`default_nettype wire

// File: sv/adev_ctrl.sv
// Controller: sequences the per-cluster divide and the final divide and roots.
`default_nettype none
module adev_ctrl #(
    parameter int SAMPLE_BITS       = adev_pkg::SAMPLE_BITS_DEF,
    parameter int CLUSTER_SIZE_BITS = adev_pkg::CLUSTER_SIZE_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                last_sample,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     cfg_ready,
    input  wire adev_pkg::adev_sts_t sts,
    output adev_pkg::adev_cmd_t      cmd
);
    import adev_pkg::*;

    localparam int NUM_W  = SAMPLE_BITS + CLUSTER_SIZE_BITS + 10;
    localparam int FIN_W  = 80;
    localparam int CNT_W  = 7;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CDIV  = 4'd1;
    localparam logic [3:0] S_CSQ   = 4'd2;
    localparam logic [3:0] S_FDIV  = 4'd3;
    localparam logic [3:0] S_R1LD  = 4'd4;
    localparam logic [3:0] S_R1    = 4'd5;
    localparam logic [3:0] S_M1    = 4'd6;
    localparam logic [3:0] S_R2LD  = 4'd7;
    localparam logic [3:0] S_R2    = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_FLD   = 4'd10;
    localparam logic [3:0] S_R1ST  = 4'd11;
    localparam logic [3:0] S_CSQ0  = 4'd12;
    localparam logic [3:0] S_R2ST  = 4'd13;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic             ov_reg, ov_next;
    logic             accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign cfg_ready = (state_reg == S_IDLE) && !ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.take_sample = 1'b1;
                    if (sts.cluster_done)
                    begin
                        cmd.div_start = 1'b1;
                        cnt_next      = CNT_W'(NUM_W);
                        pend_next     = last_sample;
                        state_next    = S_CDIV;
                    end
                    else if (last_sample)
                        state_next = S_FLD;
                end
            end
            S_CDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = S_CSQ0;
            end
            S_CSQ0:
            begin
                cmd.sq_lo  = 1'b1;
                state_next = S_CSQ;
            end
            S_CSQ:
            begin
                cmd.div_done = 1'b1;
                state_next   = pend_reg ? S_FLD : S_IDLE;
            end
            S_FLD:
            begin
                if (sts.few_clusters)
                    state_next = S_OUT;
                else
                begin
                    cmd.fin_start = 1'b1;
                    cnt_next      = CNT_W'(FIN_W);
                    state_next    = S_FDIV;
                end
            end
            S_FDIV:
            begin
                cmd.fin_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = S_R1LD;
            end
            S_R1LD:
            begin
                cmd.rt_start = 1'b1;
                cnt_next     = CNT_W'(32);
                state_next   = S_R1;
            end
            S_R1:
            begin
                cmd.rt_step = 1'b1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = S_R1ST;
            end
            S_R1ST:
            begin
                cmd.rt_store_dev = 1'b1;
                cmd.m1_start     = 1'b1;
                cnt_next         = CNT_W'(FIN_W);
                state_next       = S_M1;
            end
            S_M1:
            begin
                cmd.m1_step = 1'b1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = S_R2LD;
            end
            S_R2LD:
            begin
                cmd.rt_start  = 1'b1;
                cmd.rt_sel_q2 = 1'b1;
                cnt_next      = CNT_W'(32);
                state_next    = S_R2;
            end
            S_R2:
            begin
                cmd.rt_step = 1'b1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = S_R2ST;
            end
            S_R2ST:
            begin
                cmd.rt_store_err = 1'b1;
                state_next       = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire

// File: dv/allan_deviation_accumulator_tb.sv
// Self-checking testbench for the Allan deviation accumulator.
`timescale 1ns / 100ps
module allan_deviation_accumulator_tb;
    import adev_pkg::*;

    localparam int CSB = CLUSTER_SIZE_BITS_DEF;
    localparam longint unsigned CYCLE_LIMIT = 64'd4000000;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CSB:0]             cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [15:0]       sample;
    logic                     last_sample;
    logic                     out_valid;
    logic                     out_stall;
    logic [RES_BITS-1:0]      deviation;
    logic [RES_BITS-1:0]      error_bound;
    logic                     status;

    allan_deviation_accumulator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample(sample), .last_sample(last_sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .deviation(deviation), .error_bound(error_bound), .status(status)
    );

    typedef struct packed {
        logic [31:0] dev;
        logic [31:0] err;
        logic        sts;
    } adev_result_t;

    // Predictor state: one record in progress.
    logic [CSB:0]     size_reg;
    longint           sum_cur;
    longint           sum_prev;
    bit               have_prev;
    longint unsigned  n_in_cluster;
    longint unsigned  n_clusters;
    longint unsigned  sq_acc;

    adev_result_t     expected_results[$];
    int               fail_count;
    int               results_seen;
    int               records_sent;
    longint unsigned  cycle_count;
    bit               sender_done;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Integer square root, bit by bit.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void clear_record();
        sum_cur = 0; sum_prev = 0; have_prev = 0;
        n_in_cluster = 0; n_clusters = 0; sq_acc = 0;
    endfunction

    // Advance the predictor by one accepted sample; queue a result on last.
    function automatic void accumulate_sample(logic signed [15:0] s, logic lst);
        longint unsigned sz;
        longint          diff;
        longint unsigned mag, q, sq, d, qhi, rem, qv;
        adev_result_t    r;
        sz = size_reg;
        if (sz == 0) sz = 1;
        if (sz > (64'd1 << CSB)) sz = 64'd1 << CSB;
        sum_cur = sum_cur + longint'(s);
        if (n_in_cluster + 1 >= sz)
        begin
            if (have_prev)
            begin
                diff = sum_cur - sum_prev;
                mag = diff < 0 ? longint'(-diff) : diff;
                q = ((mag << 8) + (sz >> 1)) / sz;
                sq = q * q;
                sq_acc = (sq_acc > ~64'd0 - sq) ? ~64'd0 : sq_acc + sq;
            end
            sum_prev = sum_cur;
            have_prev = 1;
            if (n_clusters < 64'hFFFF_FFFF) n_clusters++;
            sum_cur = 0;
            n_in_cluster = 0;
        end
        else
        begin
            n_in_cluster++;
        end
        if (!lst) return;
        if (n_clusters < 2)
        begin
            r = '{dev: 32'd0, err: 32'd0, sts: 1'b1};
        end
        else
        begin
            d = 2 * (n_clusters - 1);
            qhi = sq_acc / d;
            rem = sq_acc % d;
            if (qhi >= (64'd1 << 48)) qv = ~64'd0;
            else qv = (qhi << 16) + ((rem << 16) / d);
            r.dev = 32'(int_sqrt(qv));
            r.err = 32'(int_sqrt(qv / (n_clusters + 1)));
            r.sts = 1'b0;
        end
        expected_results = {expected_results, r};
        clear_record();
    endfunction

    // Drive one sample transaction and hold it until accepted.
    task automatic send_sample(logic signed [15:0] s, logic lst);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        last_sample <= lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        accumulate_sample(s, lst);
        if (lst) records_sent++;
    endtask

    // Let the block drain before touching the register.
    task automatic wait_idle();
        while (expected_results.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_size(logic [CSB:0] v);
        in_valid <= 1'b0;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        size_reg = v;
    endtask

    // Directed rows: a size setting of 0 in a row means keep the current one.
    typedef struct {
        logic [CSB:0]       size;
        logic signed [15:0] s;
        logic               lst;
    } stim_row_t;

    stim_row_t directed[] = '{
        '{13'd1,    16'sh7FFF, 1'b1},  // one cluster only: flagged
        '{13'd0,    16'sh7FFF, 1'b0},  // full swing, size one
        '{13'd0,    16'sh8000, 1'b0},
        '{13'd0,    16'sh7FFF, 1'b0},
        '{13'd0,    16'sh8000, 1'b1},
        '{13'd0,    16'sh0000, 1'b0},  // constant input: zero deviation
        '{13'd0,    16'sh0000, 1'b0},
        '{13'd0,    16'sh0000, 1'b1},
        '{13'd2,    16'sh0003, 1'b0},  // size two
        '{13'd0,    16'sh0000, 1'b0},
        '{13'd0,    -16'sd3,   1'b0},
        '{13'd0,    16'sh0000, 1'b0},
        '{13'd0,    16'sh0001, 1'b0},
        '{13'd0,    16'sh0001, 1'b1},
        '{13'd3,    16'sh1234, 1'b0},  // partial tail is dropped
        '{13'd0,    -16'sd77,  1'b0},
        '{13'd0,    16'sh0005, 1'b0},
        '{13'd0,    16'sh0100, 1'b0},
        '{13'd0,    16'sh0200, 1'b0},
        '{13'd0,    16'sh0300, 1'b0},
        '{13'd0,    16'sh7FFF, 1'b1}
    };

    // Stimulus; the predicted result of the flagged first row is checked against a typed-in one.
    initial
    begin
        int i, k, n, len, amp;
        logic signed [15:0] v;
        logic [CSB:0] sizes[] = '{13'd0, 13'd4096, 13'd8191, 13'd1, 13'd2, 13'd5};

        rst_n = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
        in_valid = 1'b0; sample = '0; last_sample = 1'b0;
        fail_count = 0; records_sent = 0; sender_done = 0;
        size_reg = 13'd1;
        clear_record();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (i = 0; i < directed.size(); i++)
        begin
            if (directed[i].size != 0) write_size(directed[i].size);
            send_sample(directed[i].s, directed[i].lst);
            if (i == 0 && expected_results.size() != 0 &&
                expected_results[0] != adev_result_t'{dev: 32'd0, err: 32'd0, sts: 1'b1})
            begin
                $error("status: expected 1 actual %0d", expected_results[0].sts);
                fail_count++;
            end
        end

        // Extreme register settings with short records; zero and over-range
        // values act as one and the maximum size, the largest only partly filled.
        foreach (sizes[j])
        begin
            write_size(sizes[j]);
            n = (sizes[j] >= 4096) ? 8 : 4 * ((sizes[j] == 0) ? 1 : int'(sizes[j]));
            for (k = 0; k < n; k++)
                send_sample((k % 4096 == 0) ? 16'sh7FFF : 16'sh8000, k == n - 1);
        end

        // Hold off until every result is back.
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);

        // Random records: mostly well-formed, small sizes, random amplitude.
        for (i = 0; i < 1750; )
        begin
            if ($urandom_range(0, 7) == 0)
                write_size((CSB+1)'($urandom_range(0, 15) == 0 ? $urandom_range(0, 8191)
                                                               : $urandom_range(1, 6)));
            len = $urandom_range(1, 30);
            amp = $urandom_range(0, 3);
            for (k = 0; k < len; k++)
            begin
                v = 16'($urandom);
                if (amp == 0) v = $signed(v) >>> 12;
                else if (amp == 1) v = $signed(v) >>> 6;
                send_sample(v, k == len - 1);
                i++;
                // Resize mid-cluster now and then.
                if (k == len / 2 && $urandom_range(0, 9) == 0)
                begin
                    write_size((CSB+1)'($urandom_range(1, 4)));
                end
            end
        end
        in_valid <= 1'b0;
        sender_done = 1;
    end

    // Output side: draw a stall length per result, compare every accepted one.
    initial
    begin
        adev_result_t e;
        int hold;
        out_stall = 1'b1;
        results_seen = 0;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) hold = 0;
            if (hold == 0)
            begin
                out_stall <= 1'b0;
                do @(posedge clk); while (!out_valid);
            end
            else
            begin
                out_stall <= 1'b1;
                do @(posedge clk); while (!out_valid);
                repeat (hold - 1) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result with no expectation waiting");
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (deviation !== e.dev)
                begin
                    $error("deviation: expected %0d actual %0d", e.dev, deviation);
                    fail_count++;
                end
                if (error_bound !== e.err)
                begin
                    $error("error_bound: expected %0d actual %0d", e.err, error_bound);
                    fail_count++;
                end
                if (status !== e.sts)
                begin
                    $error("status: expected %0d actual %0d", e.sts, status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog and end of run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            if (sender_done && expected_results.size() == 0)
            begin
                repeat (400) @(posedge clk);
                $display("covered %0d records, %0d results, extremes of size and sample",
                         records_sent, results_seen);
                if (fail_count == 0 && expected_results.size() == 0)
                    $display("SCOREBOARD CLEAN");
                else
                    $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end
endmodule

// File: filelist.f
sv/adev_pkg.sv
sv/adev_datapath.sv
sv/adev_ctrl.sv
sv/allan_deviation_accumulator.sv
dv/allan_deviation_accumulator_tb.sv
